// ===== design/rwrb_pkg.sv =====
package rwrb_pkg;

    localparam logic [2:0] FUNC_INSERT = 3'd0;
    localparam logic [2:0] FUNC_REMOVE = 3'd1;
    localparam logic [2:0] FUNC_RAISE  = 3'd2;
    localparam logic [2:0] FUNC_LIST   = 3'd3;
    localparam logic [2:0] FUNC_LOOKUP = 3'd4;

    localparam int FILL_W  = 7;
    localparam int ENTRY_W = 72;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  source_id;
        logic [31:0] seq_index;
        logic [31:0] tag;
        logic [31:0] new_high;
    } in_item_t;

    typedef struct packed {
        logic              ok;
        logic [7:0]        out_source_id;
        logic [31:0]       out_seq_index;
        logic [31:0]       out_tag;
        logic [31:0]       missing_index;
        logic [31:0]       low_mark;
        logic [31:0]       high_mark;
        logic [FILL_W-1:0] fill;
        logic              last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } back_state_t;

endpackage

// ===== design/rwrb_ram.sv =====
module rwrb_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/rwrb_queue.sv =====
module rwrb_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    // two entries
    logic [WIDTH-1:0] data_reg [2];
    logic             wptr_reg;
    logic             wptr_next;
    logic             rptr_reg;
    logic             rptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = data_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wptr_next  = wptr_reg ^ do_push;
        rptr_next  = rptr_reg ^ do_pop;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/rwrb_front.sv =====
module rwrb_front #(
    parameter int WINDOW_SLOTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  rwrb_pkg::in_item_t              in_data,
    output logic                            push,
    output rwrb_pkg::in_item_t              push_item,
    output logic [$clog2(WINDOW_SLOTS)-1:0] push_slot,
    input  logic                            full
);

    localparam int AW = $clog2(WINDOW_SLOTS);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / WINDOW_SLOTS);
    localparam logic [7:0]  N8    = 8'(WINDOW_SLOTS);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    rwrb_pkg::in_item_t s1_item_reg;
    logic [63:0]        s1_prod_reg;
    logic [31:0]        quot;
    logic [31:0]        rem32;
    logic [7:0]         rem;
    logic               take;

    assign push      = s1_valid_reg && !full;
    assign in_ready  = !s1_valid_reg || !full;
    assign take      = in_valid && in_ready;
    assign push_item = s1_item_reg;

    // seq mod slots by reciprocal, the estimate is at most one short
    always_comb
    begin
        quot  = s1_prod_reg[63:32];
        rem32 = s1_item_reg.seq_index - 32'(quot * 32'(WINDOW_SLOTS));
        rem   = rem32[7:0];
        if (rem >= N8 + N8)
        begin
            rem = rem - N8 - N8;
        end
        else if (rem >= N8)
        begin
            rem = rem - N8;
        end
        push_slot = rem[AW-1:0];
    end

    always_comb
    begin
        s1_valid_next = take || (s1_valid_reg && full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg <= in_data;
            s1_prod_reg <= in_data.seq_index * RECIP;
        end
    end

endmodule

// ===== design/rwrb_back.sv =====
module rwrb_back #(
    parameter int WINDOW_SLOTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  rwrb_pkg::in_item_t              q_item,
    input  logic [$clog2(WINDOW_SLOTS)-1:0] q_slot,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output rwrb_pkg::out_item_t             out_data
);

    localparam int AW = $clog2(WINDOW_SLOTS);
    localparam int CW = $clog2(WINDOW_SLOTS + 1);
    localparam logic [32:0] NV = 33'(WINDOW_SLOTS);

    rwrb_pkg::back_state_t state_reg;
    rwrb_pkg::back_state_t state_next;

    logic [WINDOW_SLOTS-1:0]       occ_reg;
    logic [WINDOW_SLOTS-1:0]       occ_next;
    logic [AW-1:0]                 head_reg;
    logic [AW-1:0]                 head_next;
    logic [31:0]                   base_reg;
    logic [31:0]                   base_next;
    logic [rwrb_pkg::FILL_W-1:0]   wl_reg;
    logic [rwrb_pkg::FILL_W-1:0]   wl_next;
    logic [CW-1:0]                 i_reg;
    logic [CW-1:0]                 i_next;
    logic                          pv_reg;
    logic                          pv_next;
    logic [31:0]                   pidx_reg;
    logic [31:0]                   pidx_next;
    logic                          rd_remove_reg;
    logic                          rd_remove_next;
    logic                          out_valid_reg;
    rwrb_pkg::out_item_t           out_data_reg;

    logic                          out_free;
    logic                          emit;
    rwrb_pkg::out_item_t           res;
    logic                          we;
    logic                          re;
    logic [AW-1:0]                 raddr;
    logic [rwrb_pkg::ENTRY_W-1:0]  rdata;
    logic [32:0]                   base33;
    logic [32:0]                   high33;
    logic [32:0]                   seq33;
    logic [32:0]                   nh33;
    logic [32:0]                   diff33;
    logic                          remove_ok;
    logic                          lookup_ok;
    logic                          scan_more;
    logic [AW:0]                   cur_sum;
    logic [AW-1:0]                 cur;
    logic [31:0]                   miss;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign base33    = {1'b0, base_reg};
    assign high33    = base33 + 33'(wl_reg);
    assign seq33     = {1'b0, q_item.seq_index};
    assign nh33      = {1'b0, q_item.new_high};
    assign diff33    = nh33 - base33;
    assign remove_ok = (wl_reg != '0) && occ_reg[head_reg];
    assign lookup_ok = (wl_reg != '0) && (seq33 <= base33 + NV) && occ_reg[q_slot];
    assign scan_more = (rwrb_pkg::FILL_W'(i_reg) < wl_reg);
    assign miss      = 32'(base33 + 33'(i_reg) + 33'd1);

    // slot of the scan position, head plus offset wrapped once
    always_comb
    begin
        cur_sum = (AW+1)'(head_reg) + (AW+1)'(i_reg);
        if (cur_sum >= (AW+1)'(WINDOW_SLOTS))
        begin
            cur_sum = cur_sum - (AW+1)'(WINDOW_SLOTS);
        end
        cur = cur_sum[AW-1:0];
    end

    rwrb_ram #(
        .WIDTH (rwrb_pkg::ENTRY_W),
        .DEPTH (WINDOW_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (q_slot),
        .wdata ({q_item.source_id, q_item.seq_index, q_item.tag}),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rwrb_pkg::ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    if (q_item.func == rwrb_pkg::FUNC_LIST)
                    begin
                        state_next = rwrb_pkg::ST_SCAN;
                    end
                    else if ((q_item.func == rwrb_pkg::FUNC_REMOVE && remove_ok) ||
                             (q_item.func == rwrb_pkg::FUNC_LOOKUP && lookup_ok))
                    begin
                        state_next = rwrb_pkg::ST_READ;
                    end
                end
            end
            rwrb_pkg::ST_READ:
            begin
                if (out_free)
                begin
                    state_next = rwrb_pkg::ST_IDLE;
                end
            end
            rwrb_pkg::ST_SCAN:
            begin
                if (!scan_more && out_free)
                begin
                    state_next = rwrb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rwrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        we             = 1'b0;
        re             = 1'b0;
        raddr          = q_slot;
        emit           = 1'b0;
        res            = '0;
        res.last       = 1'b1;
        occ_next       = occ_reg;
        head_next      = head_reg;
        base_next      = base_reg;
        wl_next        = wl_reg;
        i_next         = i_reg;
        pv_next        = pv_reg;
        pidx_next      = pidx_reg;
        rd_remove_next = rd_remove_reg;
        case (state_reg)
            rwrb_pkg::ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    pop            = 1'b1;
                    rd_remove_next = (q_item.func == rwrb_pkg::FUNC_REMOVE);
                    case (q_item.func)
                        rwrb_pkg::FUNC_INSERT:
                        begin
                            emit = 1'b1;
                            if (seq33 > base33 && seq33 <= base33 + NV && !occ_reg[q_slot])
                            begin
                                we               = 1'b1;
                                occ_next[q_slot] = 1'b1;
                                res.ok           = 1'b1;
                                if (high33 < seq33)
                                begin
                                    wl_next = rwrb_pkg::FILL_W'(seq33 - base33);
                                end
                            end
                        end
                        rwrb_pkg::FUNC_REMOVE:
                        begin
                            if (remove_ok)
                            begin
                                re    = 1'b1;
                                raddr = head_reg;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        rwrb_pkg::FUNC_RAISE:
                        begin
                            emit = 1'b1;
                            if (nh33 >= high33)
                            begin
                                res.ok = 1'b1;
                                if (diff33 < NV)
                                begin
                                    wl_next = rwrb_pkg::FILL_W'(diff33);
                                end
                                else
                                begin
                                    wl_next = rwrb_pkg::FILL_W'(WINDOW_SLOTS);
                                end
                            end
                        end
                        rwrb_pkg::FUNC_LIST:
                        begin
                            i_next  = '0;
                            pv_next = 1'b0;
                        end
                        rwrb_pkg::FUNC_LOOKUP:
                        begin
                            if (lookup_ok)
                            begin
                                re = 1'b1;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            rwrb_pkg::ST_READ:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    res.ok            = 1'b1;
                    res.out_source_id = rdata[71:64];
                    res.out_seq_index = rdata[63:32];
                    res.out_tag       = rdata[31:0];
                    if (rd_remove_reg)
                    begin
                        occ_next[head_reg] = 1'b0;
                        head_next = (head_reg == AW'(WINDOW_SLOTS - 1)) ? '0 : head_reg + 1'b1;
                        base_next = rdata[63:32];
                        wl_next   = wl_reg - 1'b1;
                    end
                end
            end
            rwrb_pkg::ST_SCAN:
            begin
                // one missing index is held back so the final one can carry last
                if (scan_more)
                begin
                    if (occ_reg[cur])
                    begin
                        i_next = i_reg + 1'b1;
                    end
                    else if (!pv_reg)
                    begin
                        pv_next   = 1'b1;
                        pidx_next = miss;
                        i_next    = i_reg + 1'b1;
                    end
                    else if (out_free)
                    begin
                        emit              = 1'b1;
                        res.ok            = 1'b1;
                        res.missing_index = pidx_reg;
                        res.last          = 1'b0;
                        pidx_next         = miss;
                        i_next            = i_reg + 1'b1;
                    end
                end
                else if (out_free)
                begin
                    emit              = 1'b1;
                    res.ok            = pv_reg;
                    res.missing_index = pv_reg ? pidx_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
        res.low_mark  = base_next;
        res.high_mark = 32'({1'b0, base_next} + 33'(wl_next));
        res.fill      = wl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rwrb_pkg::ST_IDLE;
            occ_reg       <= '0;
            head_reg      <= AW'(1);
            base_reg      <= '0;
            wl_reg        <= '0;
            i_reg         <= '0;
            pv_reg        <= 1'b0;
            rd_remove_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            head_reg      <= head_next;
            base_reg      <= base_next;
            wl_reg        <= wl_next;
            i_reg         <= i_next;
            pv_reg        <= pv_next;
            rd_remove_reg <= rd_remove_next;
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= pidx_next;
        if (out_free && emit)
        begin
            out_data_reg <= res;
        end
    end

endmodule

// ===== design/receive_window_reorder_buffer_top.sv =====
// receive window of WINDOW_SLOTS slots for reordering packets by sequence index
// input channel in_valid/in_ready/in_data carries one operation per item:
// insert, remove head, raise high mark, list missing or lookup
// output channel out_valid/out_ready/out_data returns the results, each with
// the window low mark, high mark and fill after the operation; last marks the
// final result of an item
// the front registers each item with its slot index (by reciprocal multiply), then the back
// end takes the item from the queue; insert, raise and rejected ops give their
// result from the result register, remove and lookup after a registered slot ram read
// list missing walks the window's fill slots, so up to WINDOW_SLOTS, one slot a cycle
// unless a found missing index waits on a full result register
// the back end can take the next item straight after an insert, raise or rejected op,
// but not during the slot ram read of a remove or lookup or the walk of list missing
// a two entry queue separates front and back so the input keeps being taken
// while the back end works or waits
// reset empties the window: low mark 0, fill 0, all slots free
// when out_ready is low the result register holds and the back end stops,
// then the queue and front fill and in_ready drops
module receive_window_reorder_buffer_top #(
    parameter int WINDOW_SLOTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rwrb_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rwrb_pkg::out_item_t out_data
);

    localparam int AW = $clog2(WINDOW_SLOTS);
    localparam int QW = $bits(rwrb_pkg::in_item_t) + AW;

    logic               push;
    rwrb_pkg::in_item_t push_item;
    logic [AW-1:0]      push_slot;
    logic               full;
    logic               pop;
    logic               q_valid;
    logic [QW-1:0]      q_data;
    rwrb_pkg::in_item_t q_item;
    logic [AW-1:0]      q_slot;

    assign q_item = q_data[QW-1:AW];
    assign q_slot = q_data[AW-1:0];

    rwrb_front #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .push      (push),
        .push_item (push_item),
        .push_slot (push_slot),
        .full      (full)
    );

    rwrb_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_item, push_slot}),
        .full      (full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    rwrb_back #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_slot    (q_slot),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== dv/receive_window_reorder_buffer_top_tb.sv =====
module receive_window_reorder_buffer_top_tb;

    localparam int SLOTS = 64;

    // mirror of the receive window, predicts the results of each item
    class window_scoreboard;
        bit                  busy_slot [SLOTS];
        logic [7:0]          src_mem [SLOTS];
        logic [31:0]         seq_mem [SLOTS];
        logic [31:0]         tag_mem [SLOTS];
        logic [5:0]          head;
        logic [31:0]         low;
        logic [6:0]          len;
        rwrb_pkg::out_item_t pending [$];
        int                  errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                busy_slot[i] = 1'b0;
            end
            head = 6'd1;
            low = '0;
            len = '0;
            errors = 0;
        endfunction

        function rwrb_pkg::out_item_t blank();
            rwrb_pkg::out_item_t r;
            r = '0;
            r.low_mark = low;
            r.high_mark = low + 32'(len);
            r.fill = len;
            r.last = 1'b1;
            return r;
        endfunction

        function void note_item(rwrb_pkg::in_item_t it);
            logic [32:0]         base;
            logic [32:0]         top;
            logic [32:0]         sq;
            logic [32:0]         nh;
            logic [5:0]          s;
            rwrb_pkg::out_item_t r;
            int                  n;
            base = {1'b0, low};
            top = base + 33'(len);
            sq = {1'b0, it.seq_index};
            nh = {1'b0, it.new_high};
            s = it.seq_index[5:0];
            if (it.func == rwrb_pkg::FUNC_INSERT)
            begin
                if (sq > base && sq <= base + 33'(SLOTS) && !busy_slot[s])
                begin
                    busy_slot[s] = 1'b1;
                    src_mem[s] = it.source_id;
                    seq_mem[s] = it.seq_index;
                    tag_mem[s] = it.tag;
                    if (top < sq)
                    begin
                        len = 7'(sq - base);
                    end
                    r = blank();
                    r.ok = 1'b1;
                end
                else
                begin
                    r = blank();
                end
                pending.push_back(r);
            end
            else if (it.func == rwrb_pkg::FUNC_REMOVE)
            begin
                if (len != 7'd0 && busy_slot[head])
                begin
                    busy_slot[head] = 1'b0;
                    low = seq_mem[head];
                    len = len - 7'd1;
                    r = blank();
                    r.ok = 1'b1;
                    r.out_source_id = src_mem[head];
                    r.out_seq_index = seq_mem[head];
                    r.out_tag = tag_mem[head];
                    head = head + 6'd1;
                end
                else
                begin
                    r = blank();
                end
                pending.push_back(r);
            end
            else if (it.func == rwrb_pkg::FUNC_RAISE)
            begin
                if (nh >= top)
                begin
                    len = (nh - base < 33'(SLOTS)) ? 7'(nh - base) : 7'(SLOTS);
                    r = blank();
                    r.ok = 1'b1;
                end
                else
                begin
                    r = blank();
                end
                pending.push_back(r);
            end
            else if (it.func == rwrb_pkg::FUNC_LIST)
            begin
                n = 0;
                for (int i = 0; i < int'(len); i++)
                begin
                    if (!busy_slot[6'(head + 6'(i))])
                    begin
                        r = blank();
                        r.ok = 1'b1;
                        r.last = 1'b0;
                        r.missing_index = low + 32'(i) + 32'd1;
                        pending.push_back(r);
                        n++;
                    end
                end
                if (n == 0)
                begin
                    pending.push_back(blank());
                end
                else
                begin
                    pending[$].last = 1'b1;
                end
            end
            else if (it.func == rwrb_pkg::FUNC_LOOKUP)
            begin
                r = blank();
                if (len != 7'd0 && sq <= base + 33'(SLOTS) && busy_slot[s])
                begin
                    r.ok = 1'b1;
                    r.out_source_id = src_mem[s];
                    r.out_seq_index = seq_mem[s];
                    r.out_tag = tag_mem[s];
                end
                pending.push_back(r);
            end
            else
            begin
                pending.push_back(blank());
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(rwrb_pkg::out_item_t got);
            rwrb_pkg::out_item_t w;
            if (pending.size() == 0)
            begin
                report("unexpected result", 64'(got.low_mark), 64'd0);
                return;
            end
            w = pending.pop_front();
            if (got.ok !== w.ok) report("ok", 64'(got.ok), 64'(w.ok));
            if (got.out_source_id !== w.out_source_id)
                report("out_source_id", 64'(got.out_source_id), 64'(w.out_source_id));
            if (got.out_seq_index !== w.out_seq_index)
                report("out_seq_index", 64'(got.out_seq_index), 64'(w.out_seq_index));
            if (got.out_tag !== w.out_tag) report("out_tag", 64'(got.out_tag), 64'(w.out_tag));
            if (got.missing_index !== w.missing_index)
                report("missing_index", 64'(got.missing_index), 64'(w.missing_index));
            if (got.low_mark !== w.low_mark)
                report("low_mark", 64'(got.low_mark), 64'(w.low_mark));
            if (got.high_mark !== w.high_mark)
                report("high_mark", 64'(got.high_mark), 64'(w.high_mark));
            if (got.fill !== w.fill) report("fill", 64'(got.fill), 64'(w.fill));
            if (got.last !== w.last) report("last", 64'(got.last), 64'(w.last));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    rwrb_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    rwrb_pkg::out_item_t out_data;

    window_scoreboard board;
    bit stall_free;

    receive_window_reorder_buffer_top #(.WINDOW_SLOTS(SLOTS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function int gap_len();
        if (stall_free) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // valid drops only when a gap follows, so back to back items keep it high
    task send_item(rwrb_pkg::in_item_t it);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_item(it);
    endtask

    task send_op(logic [2:0] f, logic [31:0] sq, logic [31:0] nh);
        rwrb_pkg::in_item_t it;
        it.func = f;
        it.source_id = 8'($urandom);
        it.seq_index = sq;
        it.tag = $urandom;
        it.new_high = nh;
        send_item(it);
    endtask

    task wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    // accepted results checked at the edge, ready toggled at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready) board.check_result(out_data);
            out_ready <= (stall_free || $urandom_range(0, 9) < 7) ? 1'b1
                         : ($urandom_range(0, 9) < 9 ? 1'b0 : out_ready);
        end
    end

    initial
    begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [31:0] b;
        int          r;
        board = new();
        stall_free = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty window, bounds, every op and edge case
        send_op(rwrb_pkg::FUNC_REMOVE, 32'd0, 32'd0);
        send_op(rwrb_pkg::FUNC_LIST, 32'd0, 32'd0);
        send_op(rwrb_pkg::FUNC_LOOKUP, 32'd0, 32'd0);
        send_op(rwrb_pkg::FUNC_INSERT, 32'd0, 32'd0);
        send_op(rwrb_pkg::FUNC_INSERT, 32'd65, 32'd0);
        send_op(rwrb_pkg::FUNC_INSERT, 32'd64, 32'd0);
        send_op(rwrb_pkg::FUNC_INSERT, 32'd64, 32'd0);
        send_op(rwrb_pkg::FUNC_INSERT, 32'd1, 32'd0);
        send_op(rwrb_pkg::FUNC_INSERT, 32'd3, 32'd0);
        send_op(rwrb_pkg::FUNC_LIST, 32'd0, 32'd0);
        send_op(rwrb_pkg::FUNC_LOOKUP, 32'd3, 32'd0);
        send_op(rwrb_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'd0);
        send_op(rwrb_pkg::FUNC_LOOKUP, 32'd67, 32'd0);
        send_op(rwrb_pkg::FUNC_REMOVE, 32'd0, 32'd0);
        send_op(rwrb_pkg::FUNC_REMOVE, 32'd0, 32'd0);
        send_op(rwrb_pkg::FUNC_RAISE, 32'd0, 32'd10);
        send_op(rwrb_pkg::FUNC_RAISE, 32'd0, 32'hFFFF_FFFF);
        send_op(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(3'd7, 32'd0, 32'd0);
        send_op(rwrb_pkg::FUNC_LIST, 32'd0, 32'd0);
        wait_drained();

        // random: inserts near the window most often, with removes, raises, lists, lookups and unknown ops
        for (int n = 0; n < 370; n++)
        begin
            if (n == 150)
            begin
                wait_drained();
                stall_free = 1;
            end
            if (n == 220) stall_free = 0;
            b = board.low;
            r = $urandom_range(0, 99);
            if (r < 45)
                send_op(rwrb_pkg::FUNC_INSERT, b + 32'($urandom_range(0, 66)), 32'd0);
            else if (r < 47)
                send_op(rwrb_pkg::FUNC_INSERT, $urandom, 32'd0);
            else if (r < 70)
                send_op(rwrb_pkg::FUNC_REMOVE, $urandom, $urandom);
            else if (r < 78)
                send_op(rwrb_pkg::FUNC_RAISE, 32'd0, ($urandom_range(0, 3) == 0) ? $urandom
                        : b + 32'($urandom_range(0, 70)));
            else if (r < 85)
                send_op(rwrb_pkg::FUNC_LIST, $urandom, 32'd0);
            else if (r < 96)
                send_op(rwrb_pkg::FUNC_LOOKUP, ($urandom_range(0, 4) == 0) ? $urandom
                        : b + 32'($urandom_range(0, 70)), 32'd0);
            else
                send_op(3'($urandom_range(5, 7)), $urandom, $urandom);
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
